// ===== sv/saabu_pkg.sv =====
// shared types and constants of the scalar alu and branch unit
`timescale 1ns / 1ps
`default_nettype none

package saabu_pkg;

  localparam int unsigned RegCount    = 32;
  localparam int unsigned RegAddrBits = 5;
  localparam int unsigned DataBits    = 32;
  localparam int unsigned PcBits      = 10;
  localparam int unsigned ImmBits     = 16;

  localparam logic [RegAddrBits-1:0] LinkRegister = 5'd31;

  typedef enum logic [5:0] {
    OP_NOP    = 6'd0,
    OP_ORI    = 6'd1,
    OP_XORI   = 6'd2,
    OP_LUI    = 6'd3,
    OP_ADDI   = 6'd4,
    OP_SLL    = 6'd5,
    OP_SRL    = 6'd6,
    OP_SRA    = 6'd7,
    OP_SRAV   = 6'd8,
    OP_SRLV   = 6'd9,
    OP_SLLV   = 6'd10,
    OP_SUB    = 6'd11,
    OP_OR     = 6'd12,
    OP_XOR    = 6'd13,
    OP_NOR    = 6'd14,
    OP_SLT    = 6'd15,
    OP_SLTU   = 6'd16,
    OP_ADD    = 6'd17,
    OP_AND    = 6'd18,
    OP_BREAK  = 6'd19,
    OP_ANDI   = 6'd20,
    OP_J      = 6'd21,
    OP_JAL    = 6'd22,
    OP_SLTI   = 6'd23,
    OP_SLTIU  = 6'd24,
    OP_JR     = 6'd25,
    OP_JALR   = 6'd26,
    OP_BNE    = 6'd27,
    OP_BEQ    = 6'd28,
    OP_BGTZ   = 6'd29,
    OP_BLEZ   = 6'd30,
    OP_BLTZ   = 6'd31,
    OP_BLTZAL = 6'd32,
    OP_BGEZ   = 6'd33,
    OP_BGEZAL = 6'd34
  } op_t;

  typedef struct packed {
    logic [5:0]             operation;
    logic [RegAddrBits-1:0] source_index;
    logic [RegAddrBits-1:0] target_index;
    logic [RegAddrBits-1:0] dest_index;
    logic [4:0]             shift_amount;
    logic [ImmBits-1:0]     immediate;
    logic [PcBits-1:0]      jump_target;
    logic [PcBits-1:0]      current_pc;
  } in_item_t;

  typedef struct packed {
    logic                   write_enable;
    logic [RegAddrBits-1:0] write_index;
    logic [DataBits-1:0]    write_value;
    logic                   branch_taken;
    logic [PcBits-1:0]      next_pc;
    logic                   halt_request;
    logic                   interrupt_request;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/saabu_ram.sv =====
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module saabu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write returns the old contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ===== sv/scalar_alu_branch_unit.sv =====
// scalar alu and branch unit: top level with register file and execute stage
`timescale 1ns / 1ps
`default_nettype none

// executes one decoded scalar instruction per transaction against a 32 x 32
// register file (register 0 reads zero) and returns one result transaction
// with the register write, the pc redirect and the break requests
// - input channel in_valid / in_stall / in_data, result channel out_valid /
//   out_stall / out_data; a transaction moves when valid is high and stall low
// - cfg_valid / cfg_ready / cfg_data writes interrupt_on_break; cfg_ready is
//   always high, write it only while no transaction is in flight
// - a taken transaction is held in the execute stage register, and its result
//   is captured in the result register, from which it is offered
// - throughput: one transaction per cycle without stalls; the register file
//   read is issued at acceptance and the execute logic sits between the
//   operand and result registers, with the previous result forwarded
// - while out_valid and out_stall are high the result register holds, the
//   execute stage holds its instruction and in_stall rises once it is full
// - reset clears the pipeline valids, interrupt_on_break and the per entry
//   valid bits of the register file, so every register reads zero after
//   reset with no clearing pass

module scalar_alu_branch_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire saabu_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output saabu_pkg::out_item_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data
);

  import saabu_pkg::*;

  // pipeline control
  logic                   in_accept;
  logic                   s1_valid_r;
  logic                   s1_adv;
  logic                   out_free;
  in_item_t               s1_item_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  out_item_t              res;

  // config
  logic                   irq_on_break_r;

  // register file
  logic [RegCount-1:0]    rf_valid_r;
  logic                   valid_a_r;
  logic                   valid_b_r;
  logic [DataBits-1:0]    ram_a;
  logic [DataBits-1:0]    ram_b;
  logic                   rf_we;

  // forwarding of the write that lands on the same edge as the read
  logic                   fwd_valid_r;
  logic [RegAddrBits-1:0] fwd_idx_r;
  logic [DataBits-1:0]    fwd_val_r;

  // operands and intermediate values
  logic [DataBits-1:0]    op_a;
  logic [DataBits-1:0]    op_b;
  logic [DataBits-1:0]    simm;
  logic [DataBits-1:0]    zimm;
  logic [DataBits-1:0]    link_val;
  logic [PcBits-1:0]      br_target;
  logic [4:0]             var_sh;
  logic                   a_neg;
  logic                   a_zero;
  logic                   wr;
  logic [RegAddrBits-1:0] widx;
  logic [DataBits-1:0]    wval;
  logic                   taken;
  logic [PcBits-1:0]      npc;
  logic                   halt;
  logic                   intr;
  logic                   is_branch;
  logic                   wr_ok;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign rf_we     = s1_adv && res.write_enable;

  saabu_ram #(
    .WIDTH (DataBits),
    .DEPTH (RegCount)
  ) u_rf (
    .clk       (clk),
    .wr_en     (rf_we),
    .wr_addr   (res.write_index),
    .wr_data   (res.write_value),
    .rd_en     (in_accept),
    .rd_addr_a (in_data.source_index),
    .rd_addr_b (in_data.target_index),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_on_break_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      irq_on_break_r <= cfg_data;
    end
  end

  // per entry valid bits; an entry never written reads zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_valid_r <= '0;
    end else if (rf_we) begin
      rf_valid_r[res.write_index] <= 1'b1;
    end
  end

  // execute stage register, captured together with the ram read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r  <= 1'b1;
        fwd_valid_r <= rf_we;
      end else if (s1_adv) begin
        s1_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
      valid_a_r <= rf_valid_r[in_data.source_index];
      valid_b_r <= rf_valid_r[in_data.target_index];
      fwd_idx_r <= res.write_index;
      fwd_val_r <= res.write_value;
    end
  end

  // operand select: forwarded write, else ram if the entry was ever written
  always_comb begin
    if (fwd_valid_r && fwd_idx_r == s1_item_r.source_index) begin
      op_a = fwd_val_r;
    end else if (valid_a_r) begin
      op_a = ram_a;
    end else begin
      op_a = '0;
    end
    if (fwd_valid_r && fwd_idx_r == s1_item_r.target_index) begin
      op_b = fwd_val_r;
    end else if (valid_b_r) begin
      op_b = ram_b;
    end else begin
      op_b = '0;
    end
  end

  assign simm      = {{(DataBits-ImmBits){s1_item_r.immediate[ImmBits-1]}},
                      s1_item_r.immediate};
  assign zimm      = {{(DataBits-ImmBits){1'b0}}, s1_item_r.immediate};
  assign link_val  = {{(DataBits-PcBits-2){1'b0}}, s1_item_r.current_pc, 2'b00}
                     + 32'd4;
  assign br_target = s1_item_r.current_pc + simm[PcBits-1:0];
  assign var_sh    = op_a[4:0];
  assign a_neg     = op_a[DataBits-1];
  assign a_zero    = (op_a == '0);

  // instruction decode and execute
  always_comb begin
    wr        = 1'b0;
    widx      = '0;
    wval      = '0;
    taken     = 1'b0;
    npc       = '0;
    halt      = 1'b0;
    intr      = 1'b0;
    is_branch = 1'b0;
    case (op_t'(s1_item_r.operation))
      OP_ORI: begin
        wr = 1'b1; widx = s1_item_r.target_index; wval = op_a | zimm;
      end
      OP_XORI: begin
        wr = 1'b1; widx = s1_item_r.target_index; wval = op_a ^ zimm;
      end
      OP_LUI: begin
        wr = 1'b1; widx = s1_item_r.target_index;
        wval = {s1_item_r.immediate, {(DataBits-ImmBits){1'b0}}};
      end
      OP_ADDI: begin
        wr = 1'b1; widx = s1_item_r.target_index; wval = op_a + simm;
      end
      OP_ANDI: begin
        wr = 1'b1; widx = s1_item_r.target_index; wval = op_a & zimm;
      end
      OP_SLTI: begin
        wr = 1'b1; widx = s1_item_r.target_index;
        wval = {31'd0, $signed(op_a) < $signed(simm)};
      end
      OP_SLTIU: begin
        wr = 1'b1; widx = s1_item_r.target_index;
        wval = {31'd0, op_a < simm};
      end
      OP_SLL: begin
        wr = 1'b1; widx = s1_item_r.dest_index;
        wval = op_b << s1_item_r.shift_amount;
      end
      OP_SRL: begin
        wr = 1'b1; widx = s1_item_r.dest_index;
        wval = op_b >> s1_item_r.shift_amount;
      end
      OP_SRA: begin
        wr = 1'b1; widx = s1_item_r.dest_index;
        wval = $unsigned($signed(op_b) >>> s1_item_r.shift_amount);
      end
      OP_SRAV: begin
        wr = 1'b1; widx = s1_item_r.dest_index;
        wval = $unsigned($signed(op_b) >>> var_sh);
      end
      OP_SRLV: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = op_b >> var_sh;
      end
      OP_SLLV: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = op_b << var_sh;
      end
      OP_SUB: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = op_a - op_b;
      end
      OP_OR: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = op_a | op_b;
      end
      OP_XOR: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = op_a ^ op_b;
      end
      OP_NOR: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = ~(op_a | op_b);
      end
      OP_SLT: begin
        wr = 1'b1; widx = s1_item_r.dest_index;
        wval = {31'd0, $signed(op_a) < $signed(op_b)};
      end
      OP_SLTU: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = {31'd0, op_a < op_b};
      end
      OP_ADD: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = op_a + op_b;
      end
      OP_AND: begin
        wr = 1'b1; widx = s1_item_r.dest_index; wval = op_a & op_b;
      end
      OP_BREAK: begin
        halt = 1'b1;
        intr = irq_on_break_r;
      end
      OP_J: begin
        taken = 1'b1; npc = s1_item_r.jump_target;
      end
      OP_JAL: begin
        taken = 1'b1; npc = s1_item_r.jump_target;
        wr = 1'b1; widx = LinkRegister; wval = link_val;
      end
      OP_JR: begin
        taken = 1'b1; npc = op_a[PcBits+1:2];
      end
      OP_JALR: begin
        // target comes from rs as read, before rd is written
        taken = 1'b1; npc = op_a[PcBits+1:2];
        wr = 1'b1; widx = s1_item_r.dest_index; wval = link_val;
      end
      OP_BNE: begin
        is_branch = 1'b1; taken = (op_a != op_b);
      end
      OP_BEQ: begin
        is_branch = 1'b1; taken = (op_a == op_b);
      end
      OP_BGTZ: begin
        is_branch = 1'b1; taken = !a_neg && !a_zero;
      end
      OP_BLEZ: begin
        is_branch = 1'b1; taken = a_neg || a_zero;
      end
      OP_BLTZ: begin
        is_branch = 1'b1; taken = a_neg;
      end
      OP_BLTZAL: begin
        // link is written whether or not the branch goes
        is_branch = 1'b1; taken = a_neg;
        wr = 1'b1; widx = LinkRegister; wval = link_val;
      end
      OP_BGEZ: begin
        is_branch = 1'b1; taken = !a_neg;
      end
      OP_BGEZAL: begin
        is_branch = 1'b1; taken = !a_neg;
        wr = 1'b1; widx = LinkRegister; wval = link_val;
      end
      default: begin
        // nop and unused codes
        wr = 1'b0;
      end
    endcase
    if (is_branch) begin
      npc = br_target;
    end
  end

  // writes to register 0 are dropped and show as no write
  assign wr_ok = wr && (widx != '0);

  always_comb begin
    res.write_enable      = wr_ok;
    res.write_index       = wr_ok ? widx : '0;
    res.write_value       = wr_ok ? wval : '0;
    res.branch_taken      = taken;
    res.next_pc           = taken ? npc : '0;
    res.halt_request      = halt;
    res.interrupt_request = intr;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  // register 0 is never written
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> res.write_index != '0)
    else $error("register 0 written");

  // an accepted transaction occupies the execute stage next cycle
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted transaction lost");

  // input stalls only behind a blocked execute stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without cause");

  // a result with no write or no redirect carries zeros there
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.write_enable || out_data_r.write_value == '0)
                 && (out_data_r.branch_taken || out_data_r.next_pc == '0))
    else $error("unused result field not zero");

endmodule

`default_nettype wire
